@@ hdl/pftb_pkg.sv @@
// pftb_pkg: shared widths, codes and types of the per-flow token bucket policer
// used by the channel interfaces, the arithmetic unit and the top level
`timescale 1ns / 1ps

package pftb_pkg;

    localparam int SLOT_W    = 4;
    localparam int SLOT_SPAN = 2 ** SLOT_W;
    localparam int KEY_W     = 64;
    localparam int TIME_W    = 64;
    localparam int TOK_W     = 32;
    localparam int ALU_W     = TIME_W + 1;
    localparam int FLOWS_DEF = 16;

    localparam logic [TOK_W-1:0] FAST_WINDOW_RST = 32'd1000000;

    localparam logic CMD_CHECK   = 1'b0;
    localparam logic CMD_INSTALL = 1'b1;

    typedef enum logic [1:0] {
        ALU_SUB = 2'd0,
        ALU_ADD = 2'd1,
        ALU_MUL = 2'd2,
        ALU_LTU = 2'd3
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [TOK_W-1:0]  rate;
        logic [TOK_W-1:0]  burst;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] refill;
    } t_entry;

endpackage

@@ hdl/pftb_pkt_if.sv @@
// pftb_pkt_if: input item channel (check or install) with valid/ready
// depends on pftb_pkg for field widths
`timescale 1ns / 1ps

interface pftb_pkt_if import pftb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] now_ns;
    logic [SLOT_W-1:0] slot;
    logic              entry_valid;
    logic [TOK_W-1:0]  rate_q32;
    logic [TOK_W-1:0]  burst_limit;
    logic [TOK_W-1:0]  initial_tokens;

    modport source (
        output valid, command, key_high, key_low, now_ns, slot, entry_valid,
               rate_q32, burst_limit, initial_tokens,
        input  ready
    );
    modport sink (
        input  valid, command, key_high, key_low, now_ns, slot, entry_valid,
               rate_q32, burst_limit, initial_tokens,
        output ready
    );
endinterface

@@ hdl/pftb_rsp_if.sv @@
// pftb_rsp_if: result item channel with valid/ready
// depends on pftb_pkg for field widths
`timescale 1ns / 1ps

interface pftb_rsp_if import pftb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             allow;
    logic             block_request;
    logic             matched;
    logic [TOK_W-1:0] tokens_after;

    modport source (
        output valid, allow, block_request, matched, tokens_after,
        input  ready
    );
    modport sink (
        input  valid, allow, block_request, matched, tokens_after,
        output ready
    );
endinterface

@@ hdl/pftb_cfg_if.sv @@
// pftb_cfg_if: configuration write channel for the fast window register
// depends on pftb_pkg for the data width
`timescale 1ns / 1ps

interface pftb_cfg_if import pftb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/pftb_ram.sv @@
// pftb_ram: generic single write port, single read port ram with registered read
// no package dependency
`timescale 1ns / 1ps

module pftb_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                           i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                           o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pftb_alu.sv @@
// pftb_alu: shared arithmetic unit, subtract, add, 32x32 multiply, unsigned less-than
// depends on pftb_pkg; result is registered and appears in the cycle after the request
`timescale 1ns / 1ps

module pftb_alu import pftb_pkg::*; (
    input  logic             i_clk,
    input  t_alu_req         i_req,
    output logic [ALU_W-1:0] o_res
);

    logic [ALU_W-1:0] r_res;
    logic [ALU_W-1:0] n_res;
    logic [2*TOK_W-1:0] prod;

    assign prod = i_req.a[TOK_W-1:0] * i_req.b[TOK_W-1:0];

    always_comb begin
        unique case (i_req.op)
            ALU_SUB: n_res = i_req.a - i_req.b;
            ALU_ADD: n_res = i_req.a + i_req.b;
            ALU_MUL: n_res = {{(ALU_W - 2*TOK_W){1'b0}}, prod};
            ALU_LTU: n_res = {{(ALU_W - 1){1'b0}}, i_req.a < i_req.b};
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

@@ hdl/per_flow_token_bucket_policer.sv @@
// per_flow_token_bucket_policer: top level, sequencer, flow table and result register
// depends on pftb_pkg, the three channel interfaces, pftb_ram and pftb_alu
`timescale 1ns / 1ps

// usage:
//   i_pkt carries check and install items, o_rsp gives one result item per input
//   item, i_cfg writes the fast window (always ready, write only while idle).
//   one item is in work at a time; i_pkt.ready is high only while idle.
//   install: written into the table in the accept cycle, then the result is loaded.
//   check: the table is scanned from slot 0 upward, each slot with one ram read and
//   one key compare. a hit is followed by sub and compare inside the fast window, or
//   by sub, compare, two 32x32 multiplies, two adds and clip for a refill, all through
//   the one shared unit, then by the bucket update and the result load.
//   a miss scans every slot (at most 16 slots are addressable).
//   reset clears all entry valid bits, the sequencer and the output valid bit and sets
//   the fast window to 1000000 ns; the table contents are not cleared.
//   a stalled receiver holds the result in the output register; the next item is
//   still accepted and worked on, and waits only when its own result is ready.

module per_flow_token_bucket_policer import pftb_pkg::*; #(
    parameter int FLOWS = FLOWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pftb_pkt_if.sink    i_pkt,
    pftb_cfg_if.sink    i_cfg,
    pftb_rsp_if.source  o_rsp
);

    localparam int SLOTS = (FLOWS < SLOT_SPAN) ? FLOWS : SLOT_SPAN;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_RD   = 12'b000000000010,
        S_CMP  = 12'b000000000100,
        S_SUB  = 12'b000000001000,
        S_WIN  = 12'b000000010000,
        S_MLO  = 12'b000000100000,
        S_MHI  = 12'b000001000000,
        S_ADD1 = 12'b000010000000,
        S_ADD2 = 12'b000100000000,
        S_CLIP = 12'b001000000000,
        S_DEC  = 12'b010000000000,
        S_PUSH = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [TOK_W-1:0]  r_window;
    logic [SLOTS-1:0]  r_vld, n_vld;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [KEY_W-1:0]  r_kh, r_kl;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [TOK_W-1:0]  r_part, n_part;
    logic [ALU_W-1:0]  r_sum, n_sum;
    logic              r_fast, n_fast;

    logic              r_rs_allow, n_rs_allow;
    logic              r_rs_match, n_rs_match;
    logic [TOK_W-1:0]  r_rs_tokens, n_rs_tokens;

    logic              r_ovalid, n_ovalid;
    logic              r_o_allow, r_o_match;
    logic [TOK_W-1:0]  r_o_tokens;

    logic              pkt_acc;
    logic              inst_ok;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata, ent;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_alu_req          alu_req;
    logic [ALU_W-1:0]  alu_res;
    logic              key_hit;
    logic [TOK_W-1:0]  fill;
    logic              ok;
    logic              out_free;

    pftb_ram #(
        .W     ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    pftb_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign ent      = t_entry'(ram_rdata);
    assign pkt_acc  = i_pkt.valid && i_pkt.ready;
    assign inst_ok  = 32'(i_pkt.slot) < SLOTS;
    assign key_hit  = r_vld[r_idx] && (ent.key_high == r_kh) && (ent.key_low == r_kl);
    assign out_free = !r_ovalid || o_rsp.ready;

    // fast window keeps the held count, refill clips the sum at burst
    assign fill = r_fast ? ent.tokens : (alu_res[0] ? ent.burst : r_sum[TOK_W-1:0]);
    assign ok   = fill != '0;

    assign i_pkt.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_vld       = r_vld;
        n_idx       = r_idx;
        n_elapsed   = r_elapsed;
        n_part      = r_part;
        n_sum       = r_sum;
        n_fast      = r_fast;
        n_rs_allow  = r_rs_allow;
        n_rs_match  = r_rs_match;
        n_rs_tokens = r_rs_tokens;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ent;
        alu_req.op  = ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;

        unique case (r_state)
            S_IDLE: begin
                n_idx       = '0;
                n_rs_allow  = 1'b1;
                n_rs_match  = 1'b0;
                n_rs_tokens = '0;
                if (pkt_acc) begin
                    if (i_pkt.command == CMD_INSTALL) begin
                        n_state = S_PUSH;
                        if (inst_ok) begin
                            ram_we             = 1'b1;
                            ram_waddr          = i_pkt.slot[IDX_W-1:0];
                            ram_wdata.key_high = i_pkt.key_high;
                            ram_wdata.key_low  = i_pkt.key_low;
                            ram_wdata.rate     = i_pkt.rate_q32;
                            ram_wdata.burst    = i_pkt.burst_limit;
                            ram_wdata.tokens   = i_pkt.initial_tokens;
                            ram_wdata.refill   = i_pkt.now_ns;
                            n_vld[i_pkt.slot[IDX_W-1:0]] = i_pkt.entry_valid;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (key_hit) begin
                    n_state = S_SUB;
                end else if (r_idx == IDX_W'(SLOTS - 1)) begin
                    n_state = S_PUSH;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_SUB: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {1'b0, r_now};
                alu_req.b  = {1'b0, ent.refill};
                n_state    = S_WIN;
            end
            S_WIN: begin
                n_elapsed  = alu_res[TIME_W-1:0];
                alu_req.op = ALU_LTU;
                alu_req.a  = {1'b0, alu_res[TIME_W-1:0]};
                alu_req.b  = {{(ALU_W - TOK_W){1'b0}}, r_window};
                n_state    = S_MLO;
            end
            S_MLO: begin
                n_fast = alu_res[0];
                if (alu_res[0]) begin
                    n_state = S_DEC;
                end else begin
                    alu_req.op = ALU_MUL;
                    alu_req.a  = {{(ALU_W - TOK_W){1'b0}}, r_elapsed[TOK_W-1:0]};
                    alu_req.b  = {{(ALU_W - TOK_W){1'b0}}, ent.rate};
                    n_state    = S_MHI;
                end
            end
            S_MHI: begin
                // keep only the carry part of the low product
                n_part     = alu_res[2*TOK_W-1:TOK_W];
                alu_req.op = ALU_MUL;
                alu_req.a  = {{(ALU_W - TOK_W){1'b0}}, r_elapsed[TIME_W-1:TOK_W]};
                alu_req.b  = {{(ALU_W - TOK_W){1'b0}}, ent.rate};
                n_state    = S_ADD1;
            end
            S_ADD1: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = alu_res;
                alu_req.b  = {{(ALU_W - TOK_W){1'b0}}, r_part};
                n_state    = S_ADD2;
            end
            S_ADD2: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {{(ALU_W - TOK_W){1'b0}}, ent.tokens};
                alu_req.b  = {1'b0, alu_res[TIME_W-1:0]};
                n_state    = S_CLIP;
            end
            S_CLIP: begin
                n_sum      = alu_res;
                alu_req.op = ALU_LTU;
                alu_req.a  = {{(ALU_W - TOK_W){1'b0}}, ent.burst};
                alu_req.b  = alu_res;
                n_state    = S_DEC;
            end
            S_DEC: begin
                n_rs_allow  = ok;
                n_rs_match  = 1'b1;
                n_rs_tokens = ok ? (fill - TOK_W'(1)) : ent.tokens;
                if (ok) begin
                    ram_we           = 1'b1;
                    ram_wdata.tokens = fill - TOK_W'(1);
                    ram_wdata.refill = r_fast ? ent.refill : r_now;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        if ((r_state == S_PUSH) && out_free) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_window <= FAST_WINDOW_RST;
        end else begin
            r_state  <= n_state;
            r_vld    <= n_vld;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_elapsed   <= n_elapsed;
        r_part      <= n_part;
        r_sum       <= n_sum;
        r_fast      <= n_fast;
        r_rs_allow  <= n_rs_allow;
        r_rs_match  <= n_rs_match;
        r_rs_tokens <= n_rs_tokens;
        if (pkt_acc) begin
            r_kh  <= i_pkt.key_high;
            r_kl  <= i_pkt.key_low;
            r_now <= i_pkt.now_ns;
        end
        if ((r_state == S_PUSH) && out_free) begin
            r_o_allow  <= r_rs_allow;
            r_o_match  <= r_rs_match;
            r_o_tokens <= r_rs_tokens;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.allow         = r_o_allow;
    assign o_rsp.block_request = !r_o_allow;
    assign o_rsp.matched       = r_o_match;
    assign o_rsp.tokens_after  = r_o_tokens;

    a_install_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_acc && (i_pkt.command == CMD_INSTALL) |=> r_state == S_PUSH)
        else $error("install item did not go straight to the result stage");

    a_read_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_CMP)
        else $error("table read not followed by key compare");

    a_miss_no_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_rsp.matched |-> o_rsp.allow && (o_rsp.tokens_after == '0))
        else $error("unmatched result carries a denial or a token count");

    a_update_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) && !ok |-> !ram_we)
        else $error("denied packet wrote the bucket");

endmodule

@@ test/tb_pftb_checker.sv @@
// tb_pftb_checker: watches the packet, config and result channels of the policer,
// keeps its own copy of the flow table, predicts every result item and compares
// depends on pftb_pkg and the three channel interfaces
`timescale 1ns / 1ps

module tb_pftb_checker import pftb_pkg::*; #(
    parameter int FLOWS = FLOWS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pftb_pkt_if  pkt,
    pftb_cfg_if  cfg,
    pftb_rsp_if  rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_matched_count,
    output int   o_denied_count
);

    typedef struct packed {
        logic             allow;
        logic             block_request;
        logic             matched;
        logic [TOK_W-1:0] tokens_after;
    } t_verdict;

    // shadow flow table
    logic              flow_used   [FLOWS];
    logic [KEY_W-1:0]  flow_kh     [FLOWS];
    logic [KEY_W-1:0]  flow_kl     [FLOWS];
    logic [TOK_W-1:0]  flow_rate   [FLOWS];
    logic [TOK_W-1:0]  flow_burst  [FLOWS];
    logic [TOK_W-1:0]  flow_tokens [FLOWS];
    logic [TIME_W-1:0] flow_refill [FLOWS];
    logic [TOK_W-1:0]  window_ns;

    t_verdict verdict_q[$];
    t_verdict got, want;
    int       fail_total;
    int       matched_total;
    int       denied_total;

    function automatic t_verdict police_item(
        input logic              cmd,
        input logic [KEY_W-1:0]  kh,
        input logic [KEY_W-1:0]  kl,
        input logic [TIME_W-1:0] now,
        input logic [SLOT_W-1:0] slot,
        input logic              ev,
        input logic [TOK_W-1:0]  ins_rate,
        input logic [TOK_W-1:0]  ins_burst,
        input logic [TOK_W-1:0]  ins_tokens
    );
        t_verdict          v;
        int                hit;
        logic [TIME_W-1:0] elapsed;
        logic [95:0]       product;
        logic [TIME_W-1:0] gain;
        logic [TIME_W:0]   sum;
        logic [TOK_W-1:0]  fill;
        logic              ok;

        v = '{allow: 1'b1, block_request: 1'b0, matched: 1'b0, tokens_after: '0};
        if (cmd == CMD_INSTALL) begin
            if (int'(slot) < FLOWS) begin
                flow_used[slot]   = ev;
                flow_kh[slot]     = kh;
                flow_kl[slot]     = kl;
                flow_rate[slot]   = ins_rate;
                flow_burst[slot]  = ins_burst;
                flow_tokens[slot] = ins_tokens;
                flow_refill[slot] = now;
            end
            return v;
        end

        // lowest matching slot wins
        hit = -1;
        for (int i = FLOWS - 1; i >= 0; i--) begin
            if (flow_used[i] && flow_kh[i] == kh && flow_kl[i] == kl) hit = i;
        end
        if (hit < 0) return v;

        elapsed = now - flow_refill[hit];
        if (elapsed < {32'd0, window_ns}) begin
            ok = (flow_tokens[hit] != '0);
            if (ok) flow_tokens[hit] = flow_tokens[hit] - 1'b1;
        end else begin
            product = {32'd0, elapsed} * {64'd0, flow_rate[hit]};
            gain    = product[95:32];
            sum     = {1'b0, gain} + {33'd0, flow_tokens[hit]};
            if (gain >= {32'd0, flow_burst[hit]} || sum > {33'd0, flow_burst[hit]}) begin
                fill = flow_burst[hit];
            end else begin
                fill = sum[TOK_W-1:0];
            end
            ok = (fill != '0);
            if (ok) begin
                flow_tokens[hit] = fill - 1'b1;
                flow_refill[hit] = now;
            end
        end

        v.allow         = ok;
        v.block_request = !ok;
        v.matched       = 1'b1;
        v.tokens_after  = flow_tokens[hit];
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_ns = FAST_WINDOW_RST;
            for (int i = 0; i < FLOWS; i++) flow_used[i] = 1'b0;
            verdict_q.delete();
            fail_total    = 0;
            matched_total = 0;
            denied_total  = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.allow, rsp.block_request, rsp.matched, rsp.tokens_after};
                if (verdict_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("[%0t] extra result allow=%0b block=%0b matched=%0b tokens=%0d",
                                 $realtime, got.allow, got.block_request, got.matched,
                                 got.tokens_after);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.allow !== want.allow || got.block_request !== want.block_request ||
                        got.matched !== want.matched || got.tokens_after !== want.tokens_after) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("    expected allow=%0b block=%0b matched=%0b tokens=%0d",
                                     want.allow, want.block_request, want.matched,
                                     want.tokens_after);
                            $display("    actual   allow=%0b block=%0b matched=%0b tokens=%0d",
                                     got.allow, got.block_request, got.matched, got.tokens_after);
                        end
                    end
                end
            end

            if (cfg.valid && cfg.ready) window_ns = cfg.data;

            if (pkt.valid && pkt.ready) begin
                want = police_item(pkt.command, pkt.key_high, pkt.key_low, pkt.now_ns, pkt.slot,
                                   pkt.entry_valid, pkt.rate_q32, pkt.burst_limit,
                                   pkt.initial_tokens);
                if (want.matched) matched_total++;
                if (want.block_request) denied_total++;
                verdict_q.push_back(want);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= verdict_q.size();
        o_matched_count <= matched_total;
        o_denied_count  <= denied_total;
    end

endmodule

@@ test/tb_per_flow_token_bucket_policer.sv @@
// tb_per_flow_token_bucket_policer: stimulus and verdict for the token bucket policer
// drives directed then random check and install items over several fast-window values;
// depends on pftb_pkg, the channel interfaces, the policer and tb_pftb_checker
`timescale 1ns / 1ps

module tb_per_flow_token_bucket_policer;
    import pftb_pkg::*;

    localparam int ITEMS_PER_PHASE = 170;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int POOL_N          = 8;

    logic i_clk;
    logic i_rst_n;

    pftb_pkt_if pkt_ch ();
    pftb_cfg_if cfg_ch ();
    pftb_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int matched_count;
    int denied_count;

    per_flow_token_bucket_policer #(
        .FLOWS (FLOWS_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    tb_pftb_checker #(
        .FLOWS (FLOWS_DEF)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .pkt             (pkt_ch),
        .cfg             (cfg_ch),
        .rsp             (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_matched_count (matched_count),
        .o_denied_count  (denied_count)
    );

    logic [KEY_W-1:0]  pool_kh [POOL_N];
    logic [KEY_W-1:0]  pool_kl [POOL_N];
    logic [TIME_W-1:0] sim_now;
    logic [TOK_W-1:0]  cur_window;
    logic [TOK_W-1:0]  window_plan [5];
    int                idle_pct;
    int                item_count;
    int                setting_count;
    int                stall_left;
    int                quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct / 2) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((pkt_ch.valid && pkt_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic offer(
        input logic              cmd,
        input logic [KEY_W-1:0]  kh,
        input logic [KEY_W-1:0]  kl,
        input logic [TIME_W-1:0] now,
        input logic [SLOT_W-1:0] slot,
        input logic              ev,
        input logic [TOK_W-1:0]  rate,
        input logic [TOK_W-1:0]  burst,
        input logic [TOK_W-1:0]  tokens
    );
        if ($urandom_range(0, 99) < idle_pct) begin
            pkt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pkt_ch.valid          <= 1'b1;
        pkt_ch.command        <= cmd;
        pkt_ch.key_high       <= kh;
        pkt_ch.key_low        <= kl;
        pkt_ch.now_ns         <= now;
        pkt_ch.slot           <= slot;
        pkt_ch.entry_valid    <= ev;
        pkt_ch.rate_q32       <= rate;
        pkt_ch.burst_limit    <= burst;
        pkt_ch.initial_tokens <= tokens;
        @(posedge i_clk);
        while (!pkt_ch.ready) @(posedge i_clk);
        item_count++;
    endtask

    // install-only fields get noise on a check item
    task automatic do_check(
        input logic [KEY_W-1:0]  kh,
        input logic [KEY_W-1:0]  kl,
        input logic [TIME_W-1:0] now
    );
        offer(CMD_CHECK, kh, kl, now, SLOT_W'($urandom_range(0, SLOT_SPAN - 1)),
              1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        pkt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [TOK_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_window = value;
        setting_count++;
    endtask

    initial begin
        logic [KEY_W-1:0]  kh, kl;
        logic [TOK_W-1:0]  rate, burst, tokens;
        logic [TIME_W-1:0] step;
        int                pick;

        i_rst_n               <= 1'b0;
        pkt_ch.valid          <= 1'b0;
        pkt_ch.command        <= CMD_CHECK;
        pkt_ch.key_high       <= '0;
        pkt_ch.key_low        <= '0;
        pkt_ch.now_ns         <= '0;
        pkt_ch.slot           <= '0;
        pkt_ch.entry_valid    <= 1'b0;
        pkt_ch.rate_q32       <= '0;
        pkt_ch.burst_limit    <= '0;
        pkt_ch.initial_tokens <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.data           <= '0;
        idle_pct      = 20;
        item_count    = 0;
        setting_count = 0;
        sim_now       = 64'd1000;

        // key pool with partial overlaps so that half-matches get exercised
        for (int i = 0; i < POOL_N; i++) begin
            pool_kh[i] = {$urandom, $urandom};
            pool_kl[i] = {$urandom, $urandom};
        end
        pool_kh[0] = '0;
        pool_kl[0] = '0;
        pool_kh[1] = '1;
        pool_kl[1] = '1;
        pool_kh[3] = pool_kh[2];
        pool_kl[5] = pool_kl[4];

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_window(FAST_WINDOW_RST);

        // directed part
        do_check(pool_kh[0], pool_kl[0], 64'd5);
        offer(CMD_INSTALL, pool_kh[2], pool_kl[2], 64'd1000, 4'd0, 1'b1, 32'd0, 32'd2, 32'd2);
        do_check(pool_kh[2], pool_kl[2], 64'd1000);
        do_check(pool_kh[2], pool_kl[2], 64'd1500);
        // empty bucket inside the window
        do_check(pool_kh[2], pool_kl[2], 64'd2000);
        // refill with zero rate leaves it empty
        do_check(pool_kh[2], pool_kl[2], 64'd3_000_000);
        // same key in a higher slot, lower slot keeps winning
        offer(CMD_INSTALL, pool_kh[2], pool_kl[2], 64'd5000, 4'd3, 1'b1, 32'h1000_0000, 32'd5,
              32'd5);
        do_check(pool_kh[2], pool_kl[2], 64'd3_000_100);
        offer(CMD_INSTALL, pool_kh[1], pool_kl[1], 64'd0, 4'd1, 1'b1, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'd0);
        // longest possible gap at top rate saturates at burst
        do_check(pool_kh[1], pool_kl[1], 64'hFFFF_FFFF_FFFF_FFFF);
        // initial tokens above burst
        offer(CMD_INSTALL, pool_kh[4], pool_kl[4], 64'd100, 4'd2, 1'b1, 32'h8000_0000, 32'd10,
              32'd20);
        do_check(pool_kh[4], pool_kl[4], 64'd101);
        do_check(pool_kh[4], pool_kl[4], 64'd2_000_100);
        // clock going backwards looks like a long gap
        do_check(pool_kh[4], pool_kl[4], 64'd50);
        offer(CMD_INSTALL, pool_kh[2], pool_kl[2], 64'd0, 4'd0, 1'b0, $urandom, $urandom,
              $urandom);
        do_check(pool_kh[2], pool_kl[2], 64'd4_000_000);
        offer(CMD_INSTALL, pool_kh[0], pool_kl[0], 64'd1000, 4'd15, 1'b1, 32'd1, 32'd0, 32'd0);
        do_check(pool_kh[0], pool_kl[0], 64'd2_000_000);
        do_check(pool_kh[3], pool_kl[3], 64'd2_000_001);
        offer(CMD_INSTALL, pool_kh[5], pool_kl[5], 64'd7, 4'd14, 1'b1, $urandom, $urandom,
              $urandom);
        do_check(pool_kh[4], pool_kl[5], 64'd8);
        do_check(pool_kh[5], pool_kl[5], 64'd9);
        do_check({$urandom, $urandom}, {$urandom, $urandom}, 64'd10);
        drain();

        window_plan[0] = 32'd0;
        window_plan[1] = 32'hFFFF_FFFF;
        window_plan[2] = 32'd1000;
        window_plan[3] = $urandom;
        window_plan[4] = FAST_WINDOW_RST;

        for (int ph = 0; ph < 5; ph++) begin
            write_window(window_plan[ph]);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (ph == 4) idle_pct = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, POOL_N - 1);
                kh = pool_kh[pick];
                kl = pool_kl[pick];
                if ($urandom_range(0, 9) == 0) begin
                    kh = {$urandom, $urandom};
                    kl = {$urandom, $urandom};
                end
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0:       rate = 32'd0;
                        1:       rate = $urandom_range(1, 20000);
                        2:       rate = 32'hFFFF_FFFF;
                        3:       rate = $urandom;
                        default: rate = $urandom_range(1, 200000);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       burst = 32'd0;
                        1:       burst = $urandom_range(1, 8);
                        2:       burst = 32'hFFFF_FFFF;
                        3:       burst = $urandom;
                        default: burst = $urandom_range(1, 3);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       tokens = $urandom_range(0, 10);
                        1:       tokens = $urandom;
                        default: tokens = burst;
                    endcase
                    offer(CMD_INSTALL, kh, kl, sim_now,
                          SLOT_W'($urandom_range(0, SLOT_SPAN - 1)),
                          1'($urandom_range(0, 6) != 0), rate, burst, tokens);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        sim_now = sim_now + 64'($urandom_range(0, 2000));
                    end else if (pick < 65) begin
                        // land right around the window edge
                        step = {32'd0, cur_window} + 64'($urandom_range(0, 4));
                        sim_now = sim_now + step - 64'd2;
                    end else if (pick < 85) begin
                        sim_now = sim_now + 64'($urandom_range(0, 50_000_000));
                    end else if (pick < 92) begin
                        sim_now = {$urandom, $urandom};
                    end else begin
                        sim_now = sim_now - 64'($urandom_range(1, 5000));
                    end
                    do_check(kh, kl, sim_now);
                end
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("covered %0d items over %0d fast-window settings, zero and all ones included",
                 item_count, setting_count);
        $display("%0d checks found an entry, %0d of them were denied", matched_count,
                 denied_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ per_flow_token_bucket_policer.f @@
hdl/pftb_pkg.sv
hdl/pftb_pkt_if.sv
hdl/pftb_rsp_if.sv
hdl/pftb_cfg_if.sv
hdl/pftb_ram.sv
hdl/pftb_alu.sv
hdl/per_flow_token_bucket_policer.sv
test/tb_pftb_checker.sv
test/tb_per_flow_token_bucket_policer.sv
